[rtl/core/cida_pkg.sv]
package cida_pkg;

  localparam int MAX_IDS    = 16;
  localparam int ADDR_BITS  = 48;
  localparam int ID_BITS    = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CNT_BITS   = $clog2(MAX_IDS + 1);
  localparam int ACT_BITS   = 2;
  localparam int STAT_BITS  = 3;
  localparam int IN_DATA_W  = ((ADDR_BITS + ID_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ID_BITS + ADDR_BITS + 7) / 8) * 8;

  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;

  typedef enum logic [ACT_BITS-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_FIND   = 2'd3
  } action_t;

  typedef enum logic [STAT_BITS-1:0] {
    ST_ADDED   = 3'd0,
    ST_ALREADY = 3'd1,
    ST_DONE    = 3'd2,
    ST_NOT_REG = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_REMOVE,
    S_QREAD,
    S_FIN
  } state_t;

  // Advance a free-list pointer with wrap at the table depth.
  function automatic id_t next_pos(id_t p);
    next_pos = (p == id_t'(MAX_IDS - 1)) ? '0 : id_t'(p + 1'b1);
  endfunction

endpackage

[rtl/core/connection_id_allocator_unit.sv]
// Add and find go from S_SCAN through S_FIN to the output register that drives out_tvalid
//   (one address compare per cycle over up to MAX_IDS entries of the address memory).
// Remove and query run S_REMOVE or S_QREAD, then S_FIN, which low out_tready can stall.
// Handshake: in_tready is high only while idle, so the next transaction is accepted only
//   after the result loads into the output register; one transaction is in flight at a time.
// Reset: rst_n is synchronous, active low; it clears all valid bits, loads the free list
//   with IDs 0 to MAX_IDS-1 in order; the address memory is not cleared.
module connection_id_allocator_unit
  import cida_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // input transaction
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // client_address, slot_id, zero pad
  input  logic [ACT_BITS-1:0]   in_tuser,   // action
  // result transaction
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // result_id, result_address, zero pad
  output logic [STAT_BITS-1:0]  out_tuser   // status
);

  // Control and free-list state
  state_t             state_r, state_nxt;
  cnt_t               scan_r, scan_nxt;
  id_t                head_r, head_nxt;
  id_t                tail_r, tail_nxt;
  cnt_t               cnt_r, cnt_nxt;
  logic [MAX_IDS-1:0] valid_r, valid_nxt;
  id_t                fq_r [MAX_IDS];
  logic               fq_we;
  id_t                fq_wa;

  // Captured transaction
  action_t            act_r, act_nxt;
  addr_t              addr_r, addr_nxt;
  id_t                slot_r, slot_nxt;

  // Pending result
  id_t                res_id_r, res_id_nxt;
  addr_t              res_addr_r, res_addr_nxt;
  status_t            res_st_r, res_st_nxt;

  // Output register
  logic               out_valid_r, out_valid_nxt;
  id_t                out_id_r, out_id_nxt;
  addr_t              out_addr_r, out_addr_nxt;
  status_t            out_st_r, out_st_nxt;

  // Address memory: one write port, one registered read port
  addr_t              mem [MAX_IDS];
  addr_t              rdata_r;
  id_t                rd_addr;
  logic               mem_we;
  id_t                mem_wa;
  addr_t              mem_wd;

  // Input field unpack
  addr_t              in_addr;
  id_t                in_slot;
  logic               in_slot_ok;
  logic               slot_ok;
  cnt_t               scan_m1;
  id_t                cmp_idx;
  logic               hit;
  id_t                pop_id;

  assign in_addr    = in_tdata[ADDR_BITS-1:0];
  assign in_slot    = in_tdata[ADDR_BITS +: ID_BITS];
  assign in_slot_ok = {1'b0, in_slot} < cnt_t'(MAX_IDS);
  assign slot_ok    = {1'b0, slot_r} < cnt_t'(MAX_IDS);

  // The scan issues a read for entry scan_r while comparing entry scan_r-1.
  assign scan_m1 = scan_r - 1'b1;
  assign cmp_idx = scan_m1[ID_BITS-1:0];
  assign hit     = valid_r[cmp_idx] && (rdata_r == addr_r);
  assign pop_id  = fq_r[head_r];

  assign in_tready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      scan_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= cnt_t'(MAX_IDS);
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_IDS; i++) begin
        fq_r[i] <= id_t'(i);
      end
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      cnt_r       <= cnt_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fq_we) begin
        fq_r[fq_wa] <= slot_r;
      end
    end
  end

  // Payload registers need no reset
  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    addr_r     <= addr_nxt;
    slot_r     <= slot_nxt;
    res_id_r   <= res_id_nxt;
    res_addr_r <= res_addr_nxt;
    res_st_r   <= res_st_nxt;
    out_id_r   <= out_id_nxt;
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    scan_nxt      = scan_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    valid_nxt     = valid_r;
    fq_we         = 1'b0;
    fq_wa         = tail_r;
    act_nxt       = act_r;
    addr_nxt      = addr_r;
    slot_nxt      = slot_r;
    res_id_nxt    = res_id_r;
    res_addr_nxt  = res_addr_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_id_nxt    = out_id_r;
    out_addr_nxt  = out_addr_r;
    out_st_nxt    = out_st_r;
    rd_addr       = scan_r[ID_BITS-1:0];
    mem_we        = 1'b0;
    mem_wa        = pop_id;
    mem_wd        = addr_r;

    case (state_r)
      S_IDLE: begin
        // Read the slot for a query, or entry zero to start a scan.
        rd_addr = (action_t'(in_tuser) == ACT_QUERY && in_slot_ok) ? in_slot : '0;
        if (in_tvalid) begin
          act_nxt  = action_t'(in_tuser);
          addr_nxt = in_addr;
          slot_nxt = in_slot;
          scan_nxt = cnt_t'(1);
          case (action_t'(in_tuser))
            ACT_REMOVE: state_nxt = S_REMOVE;
            ACT_QUERY:  state_nxt = S_QREAD;
            default:    state_nxt = S_SCAN;
          endcase
        end
      end

      S_SCAN: begin
        res_addr_nxt = '0;
        if (hit) begin
          res_id_nxt = cmp_idx;
          res_st_nxt = (act_r == ACT_ADD) ? ST_ALREADY : ST_DONE;
          state_nxt  = S_FIN;
        end else if (scan_r == cnt_t'(MAX_IDS)) begin
          state_nxt  = S_FIN;
          res_id_nxt = '0;
          if (act_r != ACT_ADD) begin
            res_st_nxt = ST_NOT_REG;
          end else if (cnt_r == '0) begin
            res_st_nxt = ST_FULL;
          end else begin
            // Pop the oldest free ID and store the address under it.
            mem_we           = 1'b1;
            valid_nxt[pop_id] = 1'b1;
            head_nxt         = next_pos(head_r);
            cnt_nxt          = cnt_r - 1'b1;
            res_id_nxt       = pop_id;
            res_st_nxt       = ST_ADDED;
          end
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end

      S_REMOVE: begin
        res_addr_nxt = '0;
        res_id_nxt   = '0;
        res_st_nxt   = ST_NOT_REG;
        if (slot_ok && valid_r[slot_r]) begin
          valid_nxt[slot_r] = 1'b0;
          if (cnt_r < cnt_t'(MAX_IDS)) begin
            fq_we    = 1'b1;
            tail_nxt = next_pos(tail_r);
            cnt_nxt  = cnt_r + 1'b1;
          end
          res_id_nxt = slot_r;
          res_st_nxt = ST_DONE;
        end
        state_nxt = S_FIN;
      end

      S_QREAD: begin
        if (slot_ok && valid_r[slot_r]) begin
          res_id_nxt   = slot_r;
          res_addr_nxt = rdata_r;
          res_st_nxt   = ST_DONE;
        end else begin
          res_id_nxt   = '0;
          res_addr_nxt = '0;
          res_st_nxt   = ST_NOT_REG;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = res_id_r;
          out_addr_nxt  = res_addr_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - ID_BITS - ADDR_BITS){1'b0}}, out_addr_r, out_id_r};
  assign out_tuser  = out_st_r;

`ifndef SYNTHESIS
  // Every ID is either in use or on the free list.
  a_id_conservation: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(valid_r) + int'(cnt_r)) == MAX_IDS)
    else $error("valid entries and free count disagree");

  // The scan pointer stays within the compare window.
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (scan_r != '0 && scan_r <= cnt_t'(MAX_IDS)))
    else $error("scan pointer out of range");

  // Error results carry a zero ID and a zero address.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_NOT_REG || out_tuser == ST_FULL))
      |-> (out_id_r == '0 && out_addr_r == '0))
    else $error("error result with nonzero payload");

  // A new ID marks its entry valid.
  a_add_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && res_st_r == ST_ADDED) |-> valid_r[res_id_r])
    else $error("added ID not marked valid");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

typedef struct {
  cida_pkg::id_t     id;
  cida_pkg::addr_t   addr;
  cida_pkg::status_t st;
} alloc_result_t;

class alloc_scoreboard;
  cida_pkg::id_t   free_ring [cida_pkg::MAX_IDS];
  int unsigned     ring_head;
  int unsigned     ring_tail;
  int unsigned     ring_count;
  bit              live [cida_pkg::MAX_IDS];
  cida_pkg::addr_t stored [cida_pkg::MAX_IDS];
  alloc_result_t   awaited_q [$];
  int unsigned     mismatches;

  function new();
    for (int i = 0; i < cida_pkg::MAX_IDS; i++) begin
      free_ring[i] = cida_pkg::id_t'(i);
      live[i]      = 1'b0;
      stored[i]    = '0;
    end
    ring_head  = 0;
    ring_tail  = 0;
    ring_count = cida_pkg::MAX_IDS;
    mismatches = 0;
  endfunction

  // Lowest live ID holding the address, or -1.
  function int lookup(cida_pkg::addr_t a);
    for (int i = 0; i < cida_pkg::MAX_IDS; i++)
      if (live[i] && stored[i] == a) return i;
    return -1;
  endfunction

  function cida_pkg::id_t pick_live_id();
    cida_pkg::id_t ids [$];
    for (int i = 0; i < cida_pkg::MAX_IDS; i++)
      if (live[i]) ids.push_back(cida_pkg::id_t'(i));
    if (ids.size() == 0) return cida_pkg::id_t'($urandom_range(0, cida_pkg::MAX_IDS - 1));
    return ids[$urandom_range(0, ids.size() - 1)];
  endfunction

  // Update the allocator state for one accepted request and queue its response.
  function void note_input(cida_pkg::action_t act, cida_pkg::addr_t a, cida_pkg::id_t slot);
    alloc_result_t r;
    int            hit;
    cida_pkg::id_t fresh;
    r.id   = '0;
    r.addr = '0;
    r.st   = cida_pkg::ST_NOT_REG;
    case (act)
      cida_pkg::ACT_ADD: begin
        hit = lookup(a);
        if (hit >= 0) begin
          r.id = cida_pkg::id_t'(hit);
          r.st = cida_pkg::ST_ALREADY;
        end else if (ring_count == 0) begin
          r.st = cida_pkg::ST_FULL;
        end else begin
          fresh         = free_ring[ring_head];
          ring_head     = (ring_head + 1) % cida_pkg::MAX_IDS;
          ring_count--;
          live[fresh]   = 1'b1;
          stored[fresh] = a;
          r.id          = fresh;
          r.st          = cida_pkg::ST_ADDED;
        end
      end
      cida_pkg::ACT_REMOVE: begin
        if (live[slot]) begin
          live[slot] = 1'b0;
          if (ring_count < cida_pkg::MAX_IDS) begin
            free_ring[ring_tail] = slot;
            ring_tail            = (ring_tail + 1) % cida_pkg::MAX_IDS;
            ring_count++;
          end
          r.id = slot;
          r.st = cida_pkg::ST_DONE;
        end
      end
      cida_pkg::ACT_QUERY: begin
        if (live[slot]) begin
          r.id   = slot;
          r.addr = stored[slot];
          r.st   = cida_pkg::ST_DONE;
        end
      end
      default: begin
        hit = lookup(a);
        if (hit >= 0) begin
          r.id = cida_pkg::id_t'(hit);
          r.st = cida_pkg::ST_DONE;
        end
      end
    endcase
    awaited_q.push_back(r);
  endfunction

  function void check_result(cida_pkg::id_t id, cida_pkg::addr_t a, cida_pkg::status_t st);
    alloc_result_t exp_r;
    if (awaited_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected response: id=%0d addr=%h status=%s", id, a, st.name());
      return;
    end
    exp_r = awaited_q.pop_front();
    if (exp_r.id !== id || exp_r.addr !== a || exp_r.st !== st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected id=%0d addr=%h status=%s, got id=%0d addr=%h status=%s",
                 exp_r.id, exp_r.addr, exp_r.st.name(), id, a, st.name());
    end
  endfunction

  function int unsigned outstanding();
    return awaited_q.size();
  endfunction
endclass

module tb;
  import cida_pkg::*;

  localparam int LONG_HOLD   = 600;   // receiver back-pressure stretch, cycles
  localparam int STALL_LIMIT = 4000;  // cycles without any transaction before giving up
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int POOL_SIZE   = 20;    // a few more addresses than table slots

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [ACT_BITS-1:0]   in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_BITS-1:0]  out_tuser;

  alloc_scoreboard sb;
  int unsigned     results_seen;
  int unsigned     quiet_cycles;
  bit              calm;           // no new random gaps on either side while set
  addr_t           addr_pool [POOL_SIZE];

  connection_id_allocator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample both channels at the rising edge; a handshake here is a completed transaction.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_input(action_t'(in_tuser), in_tdata[ADDR_BITS-1:0],
                      in_tdata[ADDR_BITS +: ID_BITS]);
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata[ID_BITS-1:0], out_tdata[ID_BITS +: ADDR_BITS],
                        status_t'(out_tuser));
        results_seen++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Mostly back-to-back, some short gaps, now and then a long one.
  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic addr_t random_addr();
    return addr_t'({$urandom, $urandom});
  endfunction

  // Present one request from the falling edge and hold it until the block takes it.
  task automatic send_item(action_t act, addr_t a, id_t slot);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= IN_DATA_W'({slot, a});
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic idle_for(int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= IN_DATA_W'(random_addr());
      repeat (cycles) @(negedge clk);
    end
  endtask

  // Hold the sender until every queued response has come back.
  task automatic drain();
    if (sb.outstanding() != 0) begin
      in_tvalid <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clk);
    end
  endtask

  task automatic run_directed();
    addr_t all_ones;
    all_ones = '1;
    send_item(ACT_ADD, '0, '1);               // lowest address takes ID 0
    send_item(ACT_ADD, all_ones, '0);         // highest address takes ID 1
    send_item(ACT_ADD, all_ones, 4'd7);       // same address again: already registered
    send_item(ACT_FIND, all_ones, '0);
    send_item(ACT_FIND, {ADDR_BITS/2{2'b01}} , '0);  // absent address
    send_item(ACT_QUERY, '0, 4'd1);
    send_item(ACT_QUERY, all_ones, '1);       // unused slot
    send_item(ACT_REMOVE, '0, 4'd0);
    send_item(ACT_REMOVE, '0, 4'd0);          // second remove of the same ID
    send_item(ACT_FIND, '0, '0);              // address gone with its ID
    // fill the remaining fifteen slots, then overflow the table
    for (int k = 0; k < MAX_IDS - 1; k++)
      send_item(ACT_ADD, addr_t'(48'h1 << (3 * k + 1)), id_t'(k));
    send_item(ACT_ADD, {ADDR_BITS/2{2'b10}}, '0);    // table full
    send_item(ACT_ADD, all_ones, '0);         // known address still found when full
    send_item(ACT_QUERY, '0, '1);
  endtask

  task automatic run_phase(int unsigned add_pct, int unsigned rem_pct, int unsigned qry_pct);
    int unsigned roll;
    action_t     act;
    addr_t       a;
    id_t         slot;
    for (int i = 0; i < POOL_SIZE; i++)
      addr_pool[i] = random_addr();
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < add_pct)                            act = ACT_ADD;
      else if (roll < add_pct + rem_pct)             act = ACT_REMOVE;
      else if (roll < add_pct + rem_pct + qry_pct)   act = ACT_QUERY;
      else                                           act = ACT_FIND;
      // draw from the pool so that repeats and hits dominate, with some noise
      a = ($urandom_range(0, 99) < 85) ? addr_pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : random_addr();
      slot = ($urandom_range(0, 99) < 75) ? sb.pick_live_id()
                                          : id_t'($urandom_range(0, MAX_IDS - 1));
      idle_for(pick_gap());
      send_item(act, a, slot);
    end
  endtask

  // Result side: random ready pattern plus two long hold-offs that back the block up.
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned run_left;
    bit          held_early;
    bit          held_late;
    stall_left = 0;
    run_left   = 0;
    held_early = 1'b0;
    held_late  = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n && !held_early && results_seen >= 100) begin
        held_early = 1'b1;
        stall_left = LONG_HOLD;
      end else if (rst_n && !held_late && results_seen >= 1300) begin
        held_late  = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && run_left == 0 && !calm) begin
        stall_left = pick_gap();
        run_left   = $urandom_range(1, 24);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (run_left > 0) run_left--;
      end
    end
  end

  // Watchdog: give up when nothing moves on either channel for too long.
  initial begin : watchdog
    quiet_cycles = 0;
    @(posedge rst_n);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb failed");
    $finish;
  end

  initial begin : stimulus
    sb           = new();
    results_seen = 0;
    calm         = 1'b0;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = ACT_ADD;
    out_tready   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();
    drain();

    // Each phase sets its own mix: removal-heavy phases empty the table,
    // add-heavy ones run it into the full case.
    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 2 || p == 5);
      case (p % 4)
        0: run_phase(20, 45, 15);
        1: run_phase(60, 10, 15);
        2: run_phase(35, 30, 15);
        default: run_phase(45, 20, 10);
      endcase
      drain();
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/cida_pkg.sv
rtl/core/connection_id_allocator_unit.sv
dv/tb.sv
